// ===== src/mpsel_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsel_pkg
// shared types and constants for the matrix parity single error locator
// ----------------------------------------------------------------------------
package mpsel_pkg;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FIX     = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  // matrix size after reset
  localparam logic [7:0] SIZE_RESET = 8'd128;

  // controller to datapath
  typedef struct packed {
    logic sweep;      // clearing pass over the column parity memory
    logic accept;     // input transaction this cycle
    logic scan_mode;  // column scan in progress
    logic scan_step;  // column scan consumes the current entry
    logic finish;     // last scan entry, load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;   // clearing pass at its last entry
    logic matrix_done;  // last bit of the matrix is being taken
    logic scan_done;    // scan at the last column
    logic out_full;     // result register occupied and not drained this cycle
  } sts_t;

endpackage

// ===== src/mpsel_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpsel_ctrl
// sequencer: clearing pass, bit intake, column scan and result hand-off
// ----------------------------------------------------------------------------
module mpsel_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr,
  input  logic             in_valid,
  output logic             in_ready,
  input  mpsel_pkg::sts_t  sts,
  output mpsel_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.matrix_done) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_mode = 1'b1;
        // hold on the last column until the result register frees up
        cmd.scan_step = !(sts.scan_done && sts.out_full);
        cmd.finish    = sts.scan_done && !sts.out_full;
        if (cmd.finish) begin
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase
    if (cfg_wr) begin
      state_next = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/mpsel_dpath.sv =====
// ----------------------------------------------------------------------------
// mpsel_dpath
// column parity memory, position counters, row tracking and result register
// ----------------------------------------------------------------------------
module mpsel_dpath #(
  parameter int MAX_SIZE = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr,
  input  logic [7:0]       matrix_size,
  input  logic             elem_bit,
  input  mpsel_pkg::cmd_t  cmd,
  output mpsel_pkg::sts_t  sts,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       status,
  output logic [7:0]       flip_row,
  output logic [7:0]       flip_col
);

  localparam int PW = $clog2(MAX_SIZE);
  localparam int RST_SIZE = (int'(mpsel_pkg::SIZE_RESET) > MAX_SIZE) ?
                            MAX_SIZE : int'(mpsel_pkg::SIZE_RESET);
  localparam logic [PW-1:0] LAST_RST = PW'(RST_SIZE - 1);
  localparam logic [PW-1:0] IDX_END  = PW'(MAX_SIZE - 1);

  logic          mem [MAX_SIZE];
  logic          rd_raw;
  logic          byp;
  logic          byp_data;
  logic          rd_data;

  logic [PW-1:0] last_idx;
  logic [PW-1:0] last_idx_next;
  logic [PW-1:0] col;
  logic [PW-1:0] row;
  logic [PW-1:0] col_next;
  logic          row_par;
  logic [1:0]    odd_rows;
  logic [PW-1:0] first_row;
  logic [1:0]    odd_cols;
  logic [PW-1:0] first_col;
  logic [1:0]    odd_cols_next;
  logic [PW-1:0] first_col_next;
  logic [PW-1:0] idx;

  logic          col_last;
  logic          row_last;
  logic          row_odd;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic          wr_data;
  logic [PW-1:0] rd_addr;
  logic [31:0]   cfg_wide;
  logic [31:0]   frow_wide;
  logic [31:0]   fcol_wide;
  logic [1:0]    res_status;

  // size 0 runs as 1, sizes above the memory depth clamp to it
  always_comb begin
    cfg_wide = 32'(matrix_size);
    if (cfg_wide == 32'd0) begin
      last_idx_next = '0;
    end else if (cfg_wide > 32'(MAX_SIZE)) begin
      last_idx_next = IDX_END;
    end else begin
      last_idx_next = PW'(cfg_wide - 32'd1);
    end
  end

  assign col_last = (col == last_idx);
  assign row_last = (row == last_idx);
  assign row_odd  = row_par ^ elem_bit;
  assign col_next = cmd.accept ? (col_last ? '0 : col + 1'b1) : col;

  // memory port selection
  assign wr_en   = cmd.accept || cmd.sweep || cmd.scan_step;
  assign wr_addr = cmd.accept ? col : idx;
  assign wr_data = cmd.accept ? (rd_data ^ elem_bit) : 1'b0;

  always_comb begin
    if (cmd.scan_mode && !cmd.finish) begin
      rd_addr = cmd.scan_step ? idx + 1'b1 : idx;
    end else begin
      rd_addr = col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  // write-first forwarding, and a forced zero while clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      byp      <= 1'b1;
      byp_data <= 1'b0;
    end else begin
      byp      <= cmd.sweep || (wr_en && (wr_addr == rd_addr));
      byp_data <= cmd.sweep ? 1'b0 : wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_raw;

  // column scan: saturating odd count and first odd column
  always_comb begin
    odd_cols_next  = odd_cols;
    first_col_next = first_col;
    if (rd_data) begin
      if (odd_cols == 2'd0) begin
        first_col_next = idx;
      end
      if (odd_cols != 2'd2) begin
        odd_cols_next = odd_cols + 2'd1;
      end
    end
  end

  assign frow_wide = 32'(first_row) + 32'd1;
  assign fcol_wide = 32'(first_col_next) + 32'd1;

  always_comb begin
    if (odd_rows == 2'd0 && odd_cols_next == 2'd0) begin
      res_status = mpsel_pkg::ST_OK;
    end else if (odd_rows == 2'd1 && odd_cols_next == 2'd1) begin
      res_status = mpsel_pkg::ST_FIX;
    end else begin
      res_status = mpsel_pkg::ST_CORRUPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx  <= LAST_RST;
      col       <= '0;
      row       <= '0;
      row_par   <= 1'b0;
      odd_rows  <= 2'd0;
      first_row <= '0;
      odd_cols  <= 2'd0;
      first_col <= '0;
      idx       <= '0;
    end else if (cfg_wr) begin
      last_idx  <= last_idx_next;
      col       <= '0;
      row       <= '0;
      row_par   <= 1'b0;
      odd_rows  <= 2'd0;
      first_row <= '0;
      odd_cols  <= 2'd0;
      first_col <= '0;
      idx       <= '0;
    end else begin
      if (cmd.sweep) begin
        idx <= (idx == IDX_END) ? '0 : idx + 1'b1;
      end
      if (cmd.accept) begin
        col <= col_next;
        if (col_last) begin
          row_par <= 1'b0;
          row     <= row_last ? '0 : row + 1'b1;
          if (row_odd) begin
            if (odd_rows == 2'd0) begin
              first_row <= row;
            end
            if (odd_rows != 2'd2) begin
              odd_rows <= odd_rows + 2'd1;
            end
          end
        end else begin
          row_par <= row_odd;
        end
      end
      if (cmd.finish) begin
        odd_rows  <= 2'd0;
        first_row <= '0;
        odd_cols  <= 2'd0;
        first_col <= '0;
        idx       <= '0;
      end else if (cmd.scan_step) begin
        odd_cols  <= odd_cols_next;
        first_col <= first_col_next;
        idx       <= idx + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= res_status;
      if (res_status == mpsel_pkg::ST_FIX) begin
        flip_row <= frow_wide[7:0];
        flip_col <= fcol_wide[7:0];
      end else begin
        flip_row <= 8'd0;
        flip_col <= 8'd0;
      end
    end
  end

  assign sts.sweep_done  = (idx == IDX_END);
  assign sts.matrix_done = col_last && row_last;
  assign sts.scan_done   = (idx == last_idx);
  assign sts.out_full    = out_valid && !out_ready;

endmodule

// ===== src/matrix_parity_single_error_locate.sv =====
// ----------------------------------------------------------------------------
// matrix_parity_single_error_locate
// two-dimensional parity check of a square bit matrix with single error locate
// ----------------------------------------------------------------------------
// one matrix bit per cycle while in_ready is high; an n x n matrix is taken
// row by row, then its n columns are scanned through the parity memory
// the result is registered at the end of the column scan, held until taken
// reset and every matrix_size write start a clearing pass over all MAX_SIZE
// entries of the column parity memory, with in_ready low for its length
// ----------------------------------------------------------------------------
module matrix_parity_single_error_locate #(
  parameter int MAX_SIZE = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] matrix_size,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       elem_bit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] flip_row,
  output logic [7:0] flip_col
);

  mpsel_pkg::cmd_t cmd;
  mpsel_pkg::sts_t sts;
  logic            cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  mpsel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpsel_dpath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .matrix_size (matrix_size),
    .elem_bit    (elem_bit),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .flip_row    (flip_row),
    .flip_col    (flip_col)
  );

endmodule

// ===== src/mpsel_checker.sv =====
// ----------------------------------------------------------------------------
// mpsel_checker
// port-level checks for the matrix parity single error locator
// ----------------------------------------------------------------------------
module mpsel_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] flip_row,
  input logic [7:0] flip_col
);

  // a waiting result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, flip_row, flip_col}))
    else $error("result changed while stalled");

  // flip position only reported with a correctable status
  a_flip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mpsel_pkg::ST_FIX |-> flip_row == 8'd0 && flip_col == 8'd0)
    else $error("flip position given without correctable status");

  a_flip_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mpsel_pkg::ST_FIX |-> flip_row != 8'd0 && flip_col != 8'd0)
    else $error("correctable status without flip position");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == mpsel_pkg::ST_OK || status == mpsel_pkg::ST_FIX ||
                  status == mpsel_pkg::ST_CORRUPT)
    else $error("undefined status code");

  // a size write starts the clearing pass, so intake stops
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken right after size write");

endmodule

bind matrix_parity_single_error_locate mpsel_checker u_mpsel_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .flip_row  (flip_row),
  .flip_col  (flip_col)
);
